// ===== hdl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants for the DER sequence chain splitter.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // offset arithmetic widths, sums carry one extra bit so they do not wrap
    localparam int OFFSET_WIDTH = 16;
    localparam int SUM_WIDTH    = OFFSET_WIDTH + 1;

    // DER header byte codes
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] LEN_ONE_BYTE = 8'h81;
    localparam logic [7:0] LEN_TWO_BYTE = 8'h82;

    // length form codes
    localparam logic [1:0] FORM_SHORT = 2'd0;
    localparam logic [1:0] FORM_ONE   = 2'd1;
    localparam logic [1:0] FORM_TWO   = 2'd2;

    // register map, selected by paddr[2]
    localparam int         APB_ADDR_WIDTH   = 3;
    localparam logic       REG_CHAIN_LENGTH = 1'b0;
    localparam logic       REG_MAX_ENTRIES  = 1'b1;
    localparam logic [7:0] MAX_ENTRIES_RST  = 8'hFF;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // one result beat
    typedef struct packed {
        logic        last_result;
        logic        is_done;
        logic [7:0]  entry_count;
        logic [15:0] entry_length;
        logic [15:0] entry_offset;
    } result_t;

endpackage

// ===== hdl/der_sequence_chain_splitter.sv =====
// ----------------------------------------------------------------------------
// der_sequence_chain_splitter
// Splits a byte stream of concatenated DER elements into top-level SEQUENCE
// elements, reporting offset, length and count, then a done beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last
//  m_        out  m_tvalid/m_tready  m_tdata = offset,length,count,
//                                    m_tuser = is_done, m_tlast = last_result
//  apb       in   psel/penable       chain_length @0x0, max_entries @0x4
//
//  One byte is taken per cycle while s_tready is high; header decode, bounds checks and the
//  next-element sum all settle between the state registers and the
//  four-entry result queue. A byte makes zero, one or two result beats.
//  s_tready is high while the queue has room for two beats, so a stalled
//  m_ side holds the input off once three or four beats are pending.
//  aresetn (synchronous) clears the walk, the queue and the registers.
// ----------------------------------------------------------------------------
module der_sequence_chain_splitter
    import dsc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input byte stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tlast,   // last
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,   // [15:0] entry_offset,
                                                 // [31:16] entry_length,
                                                 // [39:32] entry_count
    output logic                      m_tuser,   // [0] is_done
    output logic                      m_tlast,   // last_result
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN,
        PH_EXT1,
        PH_EXT2,
        PH_BODY
    } phase_t;

    // walk state
    logic [OFFSET_WIDTH-1:0] position_reg, position_next;
    logic [OFFSET_WIDTH-1:0] element_start_reg, element_start_next;
    phase_t                  phase_reg, phase_next;
    logic [1:0]              length_form_reg, length_form_next;
    logic [15:0]             length_value_reg, length_value_next;
    logic [SUM_WIDTH-1:0]    header_end_reg, header_end_next;
    logic [SUM_WIDTH-1:0]    next_element_reg, next_element_next;
    logic [7:0]              found_count_reg, found_count_next;
    logic                    stopped_reg, stopped_next;

    // configuration
    logic [15:0]             chain_length_reg;
    logic [7:0]              max_entries_reg;

    // result queue
    result_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_WIDTH-1:0]   count_reg;

    logic                    in_fire, out_fire, cfg_write;
    logic                    finish, header_done, element_end, elem_found;
    logic                    use_elem, use_done;
    logic [SUM_WIDTH-1:0]    chain_ext, pos_ext;
    logic [15:0]             length_cur;
    result_t                 elem_res, done_res, res0, res1;
    logic [1:0]              push_count;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign chain_ext = SUM_WIDTH'(chain_length_reg);
    assign pos_ext   = SUM_WIDTH'(position_reg);

    // header decode and bounds checks for the byte at the input
    always_comb begin
        position_next      = position_reg + 1'b1;
        element_start_next = element_start_reg;
        phase_next         = phase_reg;
        length_form_next   = length_form_reg;
        header_end_next    = header_end_reg;
        next_element_next  = next_element_reg;
        found_count_next   = found_count_reg;
        stopped_next       = stopped_reg;
        length_cur         = length_value_reg;
        finish             = 1'b0;
        header_done        = 1'b0;
        element_end        = 1'b0;
        elem_found         = 1'b0;
        elem_res           = '0;

        if (!stopped_reg) begin
            case (phase_reg)
                PH_TAG: begin
                    if (found_count_reg >= max_entries_reg ||
                        position_reg >= chain_length_reg ||
                        s_tdata != TAG_SEQUENCE ||
                        pos_ext + SUM_WIDTH'(2) > chain_ext) begin
                        finish = 1'b1;
                    end else begin
                        element_start_next = position_reg;
                        header_end_next    = pos_ext + SUM_WIDTH'(2);
                        phase_next         = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (!s_tdata[7]) begin
                        length_form_next = FORM_SHORT;
                        length_cur       = {8'h00, s_tdata};
                        header_done      = 1'b1;
                    end else if (s_tdata == LEN_ONE_BYTE || s_tdata == LEN_TWO_BYTE) begin
                        length_form_next = (s_tdata == LEN_ONE_BYTE) ? FORM_ONE : FORM_TWO;
                        length_cur       = '0;
                        header_end_next  = header_end_reg + SUM_WIDTH'(length_form_next);
                        if (header_end_next > chain_ext) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = PH_EXT1;
                        end
                    end else begin
                        finish = 1'b1;
                    end
                end
                PH_EXT1, PH_EXT2: begin
                    length_cur = {length_value_reg[7:0], s_tdata};
                    if (phase_reg == PH_EXT1 && length_form_reg == FORM_TWO) begin
                        phase_next = PH_EXT2;
                    end else begin
                        header_done = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (pos_ext + SUM_WIDTH'(1) >= next_element_reg) begin
                        element_end = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_TAG;
                end
            endcase

            // complete header: bounds check and element report
            if (header_done) begin
                if (header_end_reg > chain_ext ||
                    SUM_WIDTH'(length_cur) > chain_ext - header_end_reg) begin
                    finish = 1'b1;
                end else begin
                    elem_found              = 1'b1;
                    found_count_next        = found_count_reg + 1'b1;
                    next_element_next       = header_end_reg + SUM_WIDTH'(length_cur);
                    elem_res.is_done        = 1'b0;
                    elem_res.entry_offset   = 16'(element_start_reg);
                    elem_res.entry_length   = 16'(next_element_next -
                                                  SUM_WIDTH'(element_start_reg));
                    elem_res.entry_count    = found_count_next;
                    if (length_cur == 16'd0) begin
                        element_end = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end

            // element closed: stop on limit or end of chain
            if (element_end) begin
                phase_next = PH_TAG;
                if (found_count_next >= max_entries_reg ||
                    next_element_next >= chain_ext) begin
                    finish = 1'b1;
                end
            end

            if (finish) begin
                stopped_next = 1'b1;
            end
        end

        // an element beat may be followed by a done beat from the same byte
        use_elem = elem_found;
        use_done = finish || (s_tlast && !stopped_next);

        done_res              = '0;
        done_res.is_done      = 1'b1;
        done_res.entry_count  = found_count_next;
        done_res.last_result  = 1'b1;
        elem_res.last_result  = !use_done;

        res0       = use_elem ? elem_res : done_res;
        res1       = done_res;
        push_count = {1'b0, use_elem} + {1'b0, use_done};

        length_value_next = length_cur;

        // last byte rearms the walk
        if (s_tlast) begin
            position_next      = '0;
            element_start_next = '0;
            phase_next         = PH_TAG;
            length_form_next   = FORM_SHORT;
            length_value_next  = '0;
            next_element_next  = '0;
            found_count_next   = '0;
            stopped_next       = 1'b0;
        end
    end

    // state, configuration and result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg      <= '0;
            element_start_reg <= '0;
            phase_reg         <= PH_TAG;
            length_form_reg   <= FORM_SHORT;
            length_value_reg  <= '0;
            header_end_reg    <= '0;
            next_element_reg  <= '0;
            found_count_reg   <= '0;
            stopped_reg       <= 1'b0;
            chain_length_reg  <= '0;
            max_entries_reg   <= MAX_ENTRIES_RST;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end else begin
            if (cfg_write) begin
                case (paddr[2])
                    REG_CHAIN_LENGTH: chain_length_reg <= pwdata[15:0];
                    REG_MAX_ENTRIES:  max_entries_reg  <= pwdata[7:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                position_reg      <= position_next;
                element_start_reg <= element_start_next;
                phase_reg         <= phase_next;
                length_form_reg   <= length_form_next;
                length_value_reg  <= length_value_next;
                header_end_reg    <= header_end_next;
                next_element_reg  <= next_element_next;
                found_count_reg   <= found_count_next;
                stopped_reg       <= stopped_next;
                if (push_count != 2'd0) begin
                    queue_reg[wr_ptr_reg] <= res0;
                end
                if (push_count == 2'd2) begin
                    queue_reg[wr_ptr_reg + 1'b1] <= res1;
                end
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(push_count);
            end

            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end

            count_reg <= count_reg
                       + (in_fire ? QCNT_WIDTH'(push_count) : '0)
                       - QCNT_WIDTH'(out_fire);
        end
    end

    // room for two beats keeps the input independent of m_tready
    assign s_tready = (count_reg <= QCNT_WIDTH'(QUEUE_DEPTH - 2));

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {queue_reg[rd_ptr_reg].entry_count,
                       queue_reg[rd_ptr_reg].entry_length,
                       queue_reg[rd_ptr_reg].entry_offset};
    assign m_tuser  = queue_reg[rd_ptr_reg].is_done;
    assign m_tlast  = queue_reg[rd_ptr_reg].last_result;

    // register read back
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_CHAIN_LENGTH: prdata = {16'h0000, chain_length_reg};
            REG_MAX_ENTRIES:  prdata = {24'h000000, max_entries_reg};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/dsc_checker.sv =====
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks for the DER sequence chain splitter, bound to the top.
// ----------------------------------------------------------------------------
module dsc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [39:0]               m_tdata,
    input logic                      m_tuser,
    input logic                      m_tlast
);

    // reset empties the result queue
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat pending right after reset");

    // done beats carry no offset and no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("done beat with nonzero offset or length");

    // done beat always closes the results of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("done beat without last_result");

    // an element covers at least its two header bytes and is counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:17] != 15'd0 && m_tdata[39:32] != 8'd0)
        else $error("element beat with short length or zero count");

    // a stalled result beat stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

endmodule

bind der_sequence_chain_splitter dsc_checker u_dsc_checker (.*);

// ===== tb/der_sequence_chain_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// der_sequence_chain_splitter_tb
// Self-checking bench for the DER chain splitter: byte chains go in on the
// s_ stream, a scoreboard walks the same bytes and checks every result beat
// on the m_ stream field by field. Directed corner chains come first, then
// random chains, mostly well formed, under random idling on both sides.
// ----------------------------------------------------------------------------
module der_sequence_chain_splitter_tb;
    import dsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_BYTES    = 750;
    localparam int IDLE_PCT       = 37;

    typedef enum logic [2:0] {
        WALK_TAG,
        WALK_LEN,
        WALK_EXT1,
        WALK_EXT2,
        WALK_BODY
    } walk_phase_t;

    // scoreboard: walks the chain bytes and holds the expected result beats
    class der_chain_scoreboard_t;
        logic [15:0] chain_len;
        logic [7:0]  entry_limit;
        logic [15:0] pos;
        logic [15:0] elem_start;
        walk_phase_t phase;
        logic [1:0]  form;
        logic [15:0] len_val;
        logic [16:0] next_elem;
        logic [7:0]  found;
        bit          halted;
        result_t     expected_q[$];
        int          errors;
        int          live_bytes;
        int          total_bytes;
        int          element_beats;
        int          done_beats;

        function new();
            chain_len   = 16'd0;
            entry_limit = MAX_ENTRIES_RST;
            errors      = 0;
            live_bytes  = 0;
            total_bytes = 0;
            element_beats = 0;
            done_beats  = 0;
            rearm();
        endfunction

        function void rearm();
            pos        = 16'd0;
            elem_start = 16'd0;
            phase      = WALK_TAG;
            form       = FORM_SHORT;
            len_val    = 16'd0;
            next_elem  = 17'd0;
            found      = 8'd0;
            halted     = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_CHAIN_LENGTH)
                chain_len = value[15:0];
            else
                entry_limit = value[7:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic done, logic [15:0] off, logic [15:0] len,
                                  logic [7:0] cnt);
            result_t r;
            r.last_result  = 1'b0;
            r.is_done      = done;
            r.entry_offset = off;
            r.entry_length = len;
            r.entry_count  = cnt;
            expected_q.push_back(r);
        endfunction

        // one accepted input beat
        function void note_byte(logic [7:0] b, logic last);
            int unsigned hend;
            bit          finish;
            bit          hdr_done;
            bit          elem_end;
            int          n_before;
            finish   = 1'b0;
            hdr_done = 1'b0;
            elem_end = 1'b0;
            n_before = expected_q.size();
            total_bytes++;
            if (!halted) begin
                live_bytes++;
                case (phase)
                    WALK_TAG: begin
                        if (found >= entry_limit || pos >= chain_len ||
                            b != TAG_SEQUENCE || pos + 2 > chain_len) begin
                            finish = 1'b1;
                        end else begin
                            elem_start = pos;
                            phase = WALK_LEN;
                        end
                    end
                    WALK_LEN: begin
                        if (b < 8'h80) begin
                            form = FORM_SHORT;
                            len_val = {8'd0, b};
                            hdr_done = 1'b1;
                        end else if (b == LEN_ONE_BYTE || b == LEN_TWO_BYTE) begin
                            form = (b == LEN_ONE_BYTE) ? FORM_ONE : FORM_TWO;
                            len_val = 16'd0;
                            if (elem_start + 2 + form > chain_len)
                                finish = 1'b1;
                            else
                                phase = WALK_EXT1;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    WALK_EXT1, WALK_EXT2: begin
                        len_val = {len_val[7:0], b};
                        if (phase == WALK_EXT1 && form == FORM_TWO)
                            phase = WALK_EXT2;
                        else
                            hdr_done = 1'b1;
                    end
                    default: begin
                        if (pos + 1 >= next_elem)
                            elem_end = 1'b1;
                    end
                endcase

                // header complete: bounds check, then report the element
                if (hdr_done) begin
                    hend = elem_start + 2 + form;
                    if (hend > chain_len || len_val > chain_len - hend) begin
                        finish = 1'b1;
                    end else begin
                        found++;
                        next_elem = 17'(hend + len_val);
                        push_result(1'b0, elem_start, 16'(next_elem - elem_start), found);
                        if (len_val == 16'd0)
                            elem_end = 1'b1;
                        else
                            phase = WALK_BODY;
                    end
                end

                if (elem_end) begin
                    phase = WALK_TAG;
                    if (found >= entry_limit || next_elem >= chain_len)
                        finish = 1'b1;
                end

                if (finish) begin
                    push_result(1'b1, 16'd0, 16'd0, found);
                    halted = 1'b1;
                end
            end

            pos = pos + 16'd1;

            // last byte closes the chain and rearms the walk
            if (last) begin
                if (!halted)
                    push_result(1'b1, 16'd0, 16'd0, found);
                rearm();
            end

            if (expected_q.size() > n_before)
                expected_q[expected_q.size() - 1].last_result = 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // one accepted result beat against the oldest expectation
        function void check_beat(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: done %0d offset %0d length %0d count %0d",
                       got.is_done, got.entry_offset, got.entry_length, got.entry_count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("is_done", want.is_done, got.is_done);
            compare_field("entry_offset", want.entry_offset, got.entry_offset);
            compare_field("entry_length", want.entry_length, got.entry_length);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("last_result", want.last_result, got.last_result);
            if (want.is_done)
                done_beats++;
            else
                element_beats++;
        endfunction
    endclass

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata  = 8'd0;
    logic                      s_tlast  = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [39:0]               m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr    = '0;
    logic [31:0]               pwdata   = 32'd0;
    logic [31:0]               prdata;
    logic                      pready;

    der_chain_scoreboard_t sb = new();
    logic [7:0] chain_bytes[$];
    bit         no_gaps      = 1'b0;
    bit         hold_request = 1'b0;
    int         chains_run   = 0;
    int         stall_cycles = 0;
    int         quiet_cycles = 0;

    der_sequence_chain_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // result sink with random back-pressure and one long hold-off
    initial begin : result_sink
        int      hold_left;
        result_t got;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.entry_offset = m_tdata[15:0];
                got.entry_length = m_tdata[31:16];
                got.entry_count  = m_tdata[39:32];
                got.is_done      = m_tuser;
                got.last_result  = m_tlast;
                sb.check_beat(got);
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (s_tvalid && !s_tready)
            stall_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("der_sequence_chain_splitter verification failed");
            $finish;
        end
    end

    // one register write, psel left high so writes can run back to back
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input logic [15:0] clen, input bit set_limit,
                             input logic [7:0] limit);
        apb_write(REG_CHAIN_LENGTH, {16'd0, clen});
        if (set_limit)
            apb_write(REG_MAX_ENTRIES, {24'd0, limit});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one byte, with random gaps ahead of it
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
    endtask

    // wait until every expected beat has come out, then let the block settle
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // program the registers, send chain_bytes with last on the final byte
    task automatic run_chain(input logic [15:0] clen, input bit set_limit,
                             input logic [7:0] limit);
        configure(clen, set_limit, limit);
        for (int i = 0; i < chain_bytes.size(); i++)
            push_byte(chain_bytes[i], i == chain_bytes.size() - 1);
        s_tvalid <= 1'b0;
        chains_run++;
        wait_drained();
    endtask

    // random chain: mostly well-formed elements, some cut, corrupted or noise
    task automatic run_random_chain();
        int unsigned n_elem;
        int unsigned form;
        int unsigned content;
        int unsigned clen;
        int unsigned pick;
        int unsigned idx;
        bit          set_limit;
        logic [7:0]  limit;
        chain_bytes.delete();
        pick   = $urandom_range(0, 9);
        n_elem = $urandom_range(1, 4);
        for (int e = 0; e < n_elem; e++) begin
            form = $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                content = 0;
            else
                content = $urandom_range(1, (form == 0) ? 20 : 48);
            chain_bytes.push_back(TAG_SEQUENCE);
            if (form == 0) begin
                chain_bytes.push_back(8'(content));
            end else if (form == 1) begin
                chain_bytes.push_back(LEN_ONE_BYTE);
                chain_bytes.push_back(8'(content));
            end else begin
                chain_bytes.push_back(LEN_TWO_BYTE);
                chain_bytes.push_back(8'(content >> 8));
                chain_bytes.push_back(8'(content));
            end
            repeat (content) chain_bytes.push_back(8'($urandom));
        end
        clen = chain_bytes.size();

        case (pick)
            0: begin
                // declared length too short: header or content runs past it
                idx = $urandom_range(1, 6);
                clen = (clen > idx) ? clen - idx : 0;
            end
            1: begin
                // declared length too long, trailing bytes after the elements
                clen = clen + $urandom_range(1, 10);
                repeat ($urandom_range(1, 6)) begin
                    chain_bytes.push_back(($urandom_range(0, 1) == 0) ? TAG_SEQUENCE
                                                                      : 8'($urandom));
                end
            end
            2: begin
                idx = $urandom_range(0, chain_bytes.size() - 1);
                chain_bytes[idx] = 8'($urandom);
            end
            3: begin
                // chain cut short by an early last byte
                idx = $urandom_range(1, chain_bytes.size());
                while (chain_bytes.size() > idx)
                    void'(chain_bytes.pop_back());
            end
            4: begin
                chain_bytes.delete();
                repeat ($urandom_range(1, 10)) chain_bytes.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    chain_bytes[0] = TAG_SEQUENCE;
                clen = $urandom_range(0, 32);
            end
            default: begin
            end
        endcase

        // bytes past the stop point now and then
        if (pick != 3 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) chain_bytes.push_back(8'($urandom));

        // register extremes
        case ($urandom_range(0, 19))
            0: clen = 0;
            1: clen = 16'hFFFF;
            default: begin
            end
        endcase

        set_limit = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 7))
            0: limit = 8'd0;
            1, 2: limit = 8'($urandom_range(1, n_elem));
            default: limit = MAX_ENTRIES_RST;
        endcase
        run_chain(16'(clen), set_limit, limit);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty walk with chain_length still zero
        chain_bytes = '{TAG_SEQUENCE, 8'h00};
        run_chain(16'd0, 1'b0, 8'd0);
        // empty walk with max_entries zero
        chain_bytes = '{TAG_SEQUENCE, 8'h00};
        run_chain(16'd2, 1'b1, 8'd0);
        // empty content element ending exactly at the chain length
        chain_bytes = '{TAG_SEQUENCE, 8'h00};
        run_chain(16'd2, 1'b1, MAX_ENTRIES_RST);
        // tag with under two bytes left
        chain_bytes = '{TAG_SEQUENCE};
        run_chain(16'd1, 1'b0, 8'd0);
        // wrong tag
        chain_bytes = '{8'h31, 8'h00};
        run_chain(16'd4, 1'b0, 8'd0);
        // indefinite length form
        chain_bytes = '{TAG_SEQUENCE, 8'h80};
        run_chain(16'd4, 1'b0, 8'd0);
        // unsupported long length form
        chain_bytes = '{TAG_SEQUENCE, 8'h83};
        run_chain(16'd4, 1'b0, 8'd0);
        // two-byte length header running past the chain length
        chain_bytes = '{TAG_SEQUENCE, LEN_TWO_BYTE, 8'h00};
        run_chain(16'd3, 1'b0, 8'd0);
        // content running past the chain length
        chain_bytes = '{TAG_SEQUENCE, 8'h05};
        run_chain(16'd4, 1'b0, 8'd0);
        // full-size element, chain cut short by the last byte
        chain_bytes = '{TAG_SEQUENCE, LEN_TWO_BYTE, 8'hFF, 8'hFB, 8'h12, 8'h34};
        run_chain(16'hFFFF, 1'b0, 8'd0);
        // entry limit reached, the rest swallowed
        chain_bytes = '{TAG_SEQUENCE, LEN_ONE_BYTE, 8'h00, TAG_SEQUENCE, 8'h00};
        run_chain(16'd5, 1'b1, 8'd1);

        // long receiver hold-off over a chain of empty elements
        chain_bytes.delete();
        repeat (20) begin
            chain_bytes.push_back(TAG_SEQUENCE);
            chain_bytes.push_back(8'h00);
        end
        hold_request = 1'b1;
        run_chain(16'd40, 1'b1, MAX_ENTRIES_RST);

        // random chains, with one stretch of no idling
        while (sb.total_bytes < TOTAL_BYTES) begin
            no_gaps = (sb.total_bytes >= 300 && sb.total_bytes < 420);
            run_random_chain();
        end
        no_gaps = 1'b0;

        wait_drained();
        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end

        $display("run covered %0d chains, %0d bytes (%0d walked), %0d element and %0d done beats",
                 chains_run, sb.total_bytes, sb.live_bytes, sb.element_beats,
                 sb.done_beats);
        $display("input held off by back-pressure for %0d cycles", stall_cycles);
        if (sb.errors == 0) begin
            $display("der_sequence_chain_splitter verification clean");
        end else begin
            $display("der_sequence_chain_splitter verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsc_pkg.sv
hdl/der_sequence_chain_splitter.sv
hdl/dsc_checker.sv
tb/der_sequence_chain_splitter_tb.sv
